FILE: hdl/ffa_pkg.sv
// ffa_pkg: shared types and codes of the first-fit free-list allocator
// used by ffa_ctrl, ffa_dp and the top level; no dependencies
package ffa_pkg;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam int WA_W = 2;
    localparam logic [WA_W-1:0] WA_IDX  = 2'd0;
    localparam logic [WA_W-1:0] WA_M1   = 2'd1;
    localparam logic [WA_W-1:0] WA_ZERO = 2'd2;

    localparam int WS_W = 3;
    localparam logic [WS_W-1:0] WS_COPY     = 3'd0;
    localparam logic [WS_W-1:0] WS_TRIM     = 3'd1;
    localparam logic [WS_W-1:0] WS_MRG_BOTH = 3'd2;
    localparam logic [WS_W-1:0] WS_MRG_PREV = 3'd3;
    localparam logic [WS_W-1:0] WS_MRG_NXT  = 3'd4;
    localparam logic [WS_W-1:0] WS_NEW      = 3'd5;
    localparam logic [WS_W-1:0] WS_INIT     = 3'd6;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_HOLD = 3'd0;
    localparam logic [IDX_W-1:0] IDX_CLR  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_INC  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_DEC  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_CNT  = 3'd4;

    typedef struct packed {
        logic                init;
        logic                load;
        logic                rd;
        logic                rd_m1;
        logic                wr;
        logic [WA_W-1:0]     wr_addr;
        logic [WS_W-1:0]     wr_src;
        logic [IDX_W-1:0]    idx_op;
        logic                pos_ld;
        logic                prev_ld;
        logic                nxt_ld;
        logic                nb_clr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                res_wr;
        logic                res_alloc;
        logic [STATUS_W-1:0] res_code;
        logic                respond;
    } ffa_cmd_t;

    typedef struct packed {
        logic req_free;
        logic amt_zero;
        logic range_bad;
        logic idx_lt_cnt;
        logic fit;
        logic exact;
        logic off_le_start;
        logic ovl;
        logic prev_adj;
        logic nxt_adj;
        logic full;
        logic rm_more;
        logic ins_more;
    } ffa_stat_t;

endpackage

FILE: hdl/first_fit_free_list_allocator_core.sv
// first_fit_free_list_allocator_core: top level of the first-fit free-list allocator
// depends on ffa_pkg, ffa_ctrl and ffa_dp
//
// A request is taken when start is high and busy is low; exactly one result comes back
// later on offset_out, length_out and status with done high for a single cycle, and it
// must be taken in that cycle. Requests are handled one at a time by a state machine
// walking a chunk table with one read port and one write port (one read, one write per
// cycle, registered read). An allocate that exactly fits a chunk removes it by moving
// the later entries down; a free that merges both neighbours does the same, and a free
// that inserts a new chunk moves the later entries up. After reset and after a write of
// total_size made while the controller is idle, the table is rebuilt while busy is
// high; a write made during a request does not rebuild it.
module first_fit_free_list_allocator_core #(
    parameter int MAX_CHUNKS = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] amount,
    input  logic [31:0] start_req,
    input  logic        total_size_we,
    input  logic [31:0] total_size_wdata,
    output logic        done,
    output logic [31:0] offset_out,
    output logic [31:0] length_out,
    output logic [ffa_pkg::STATUS_W-1:0] status
);

    ffa_pkg::ffa_cmd_t  cmd;
    ffa_pkg::ffa_stat_t st;

    ffa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .total_size_we (total_size_we),
        .st            (st),
        .cmd           (cmd),
        .busy          (busy)
    );

    ffa_dp #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .total_size_we    (total_size_we),
        .total_size_wdata (total_size_wdata),
        .mode             (mode),
        .amount           (amount),
        .start_req        (start_req),
        .offset_out       (offset_out),
        .length_out       (length_out),
        .status           (status),
        .done             (done)
    );

endmodule

FILE: hdl/ffa_ctrl.sv
// ffa_ctrl: sequencing state machine of the allocator
// depends on ffa_pkg; drives ffa_dp through ffa_cmd_t, reads ffa_stat_t
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              total_size_we,
    input  ffa_pkg::ffa_stat_t st,
    output ffa_pkg::ffa_cmd_t  cmd,
    output logic              busy
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_A_SCAN  = 4'd3;
    localparam logic [3:0] S_A_CMP   = 4'd4;
    localparam logic [3:0] S_F_SCAN  = 4'd5;
    localparam logic [3:0] S_F_CMP   = 4'd6;
    localparam logic [3:0] S_F_CHK   = 4'd7;
    localparam logic [3:0] S_RM_CHK  = 4'd8;
    localparam logic [3:0] S_RM_RD   = 4'd9;
    localparam logic [3:0] S_RM_WR   = 4'd10;
    localparam logic [3:0] S_INS_CHK = 4'd11;
    localparam logic [3:0] S_INS_WR  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE) || total_size_we;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init    = 1'b1;
                cmd.wr      = 1'b1;
                cmd.wr_addr = ffa_pkg::WA_ZERO;
                cmd.wr_src  = ffa_pkg::WS_INIT;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                priority if (total_size_we)
                begin
                    state_next = S_INIT;
                end
                else if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DECODE:
            begin
                priority if (!st.req_free)
                begin
                    cmd.idx_op = ffa_pkg::IDX_CLR;
                    state_next = S_A_SCAN;
                end
                else if (st.amt_zero)
                begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = ffa_pkg::ST_OK;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (st.range_bad)
                begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = ffa_pkg::ST_BADFREE;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = ffa_pkg::IDX_CLR;
                    cmd.nb_clr = 1'b1;
                    state_next = S_F_SCAN;
                end
            end
            S_A_SCAN:
            begin
                if (st.idx_lt_cnt)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_A_CMP;
                end
                else
                begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = ffa_pkg::ST_NOSPACE;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_A_CMP:
            begin
                if (st.fit)
                begin
                    cmd.res_wr    = 1'b1;
                    cmd.res_alloc = 1'b1;
                    cmd.res_code  = ffa_pkg::ST_OK;
                    if (st.exact)
                    begin
                        state_next = S_RM_CHK;
                    end
                    else
                    begin
                        cmd.wr      = 1'b1;
                        cmd.wr_addr = ffa_pkg::WA_IDX;
                        cmd.wr_src  = ffa_pkg::WS_TRIM;
                        cmd.respond = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_op = ffa_pkg::IDX_INC;
                    state_next = S_A_SCAN;
                end
            end
            S_F_SCAN:
            begin
                if (st.idx_lt_cnt)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_F_CMP;
                end
                else
                begin
                    state_next = S_F_CHK;
                end
            end
            S_F_CMP:
            begin
                if (st.off_le_start)
                begin
                    cmd.prev_ld = 1'b1;
                    cmd.idx_op  = ffa_pkg::IDX_INC;
                    state_next  = S_F_SCAN;
                end
                else
                begin
                    cmd.nxt_ld = 1'b1;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                cmd.res_wr   = 1'b1;
                cmd.res_code = ffa_pkg::ST_OK;
                priority if (st.ovl)
                begin
                    cmd.res_code = ffa_pkg::ST_BADFREE;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (st.prev_adj && st.nxt_adj)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_addr = ffa_pkg::WA_M1;
                    cmd.wr_src  = ffa_pkg::WS_MRG_BOTH;
                    state_next  = S_RM_CHK;
                end
                else if (st.prev_adj)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_addr = ffa_pkg::WA_M1;
                    cmd.wr_src  = ffa_pkg::WS_MRG_PREV;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (st.nxt_adj)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_addr = ffa_pkg::WA_IDX;
                    cmd.wr_src  = ffa_pkg::WS_MRG_NXT;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (st.full)
                begin
                    cmd.res_code = ffa_pkg::ST_FULL;
                    cmd.respond  = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.pos_ld = 1'b1;
                    cmd.idx_op = ffa_pkg::IDX_CNT;
                    state_next = S_INS_CHK;
                end
            end
            S_RM_CHK:
            begin
                if (st.rm_more)
                begin
                    cmd.idx_op = ffa_pkg::IDX_INC;
                    state_next = S_RM_RD;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_addr = ffa_pkg::WA_M1;
                cmd.wr_src  = ffa_pkg::WS_COPY;
                state_next  = S_RM_CHK;
            end
            S_INS_CHK:
            begin
                if (st.ins_more)
                begin
                    cmd.rd     = 1'b1;
                    cmd.rd_m1  = 1'b1;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_addr = ffa_pkg::WA_IDX;
                    cmd.wr_src  = ffa_pkg::WS_NEW;
                    cmd.cnt_inc = 1'b1;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_INS_WR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_addr = ffa_pkg::WA_IDX;
                cmd.wr_src  = ffa_pkg::WS_COPY;
                cmd.idx_op  = ffa_pkg::IDX_DEC;
                state_next  = S_INS_CHK;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_respond_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> (state_reg == S_IDLE))
        else $error("response issued before the request finished");

endmodule

FILE: hdl/ffa_dp.sv
// ffa_dp: chunk table memory, request registers, compares and result registers
// depends on ffa_pkg; controlled by ffa_ctrl
module ffa_dp #(
    parameter int MAX_CHUNKS = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ffa_pkg::ffa_cmd_t  cmd,
    output ffa_pkg::ffa_stat_t st,
    input  logic              total_size_we,
    input  logic [31:0]       total_size_wdata,
    input  logic              mode,
    input  logic [31:0]       amount,
    input  logic [31:0]       start_req,
    output logic [31:0]       offset_out,
    output logic [31:0]       length_out,
    output logic [ffa_pkg::STATUS_W-1:0] status,
    output logic              done
);

    localparam int AW = ADDR_WIDTH;
    localparam int EW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 1;
    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam logic [EW-1:0] ADDR_MASK = {{(EW - AW){1'b0}}, {AW{1'b1}}};
    localparam logic [31:0] TOTAL_RESET = 32'd65536;

    logic [2*AW-1:0] chunk_mem [MAX_CHUNKS];
    logic [2*AW-1:0] rd_data_reg;

    logic [31:0]   total_size_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg;
    logic          prev_v_reg, prev_v_next;
    logic          nxt_v_reg, nxt_v_next;
    logic          done_reg;

    logic          req_mode_reg;
    logic [31:0]   req_amount_reg;
    logic [31:0]   req_start_reg;
    logic [AW-1:0] prev_off_reg, prev_len_reg;
    logic [AW-1:0] nxt_off_reg, nxt_len_reg;
    logic [31:0]   res_off_reg, res_len_reg;
    logic [ffa_pkg::STATUS_W-1:0] res_status_reg;

    logic [CW-1:0] idx_m1;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [AW-1:0] wr_off, wr_len;
    logic [EW-1:0] start_x, amt_x, end_x, total_x;
    logic [EW-1:0] rd_off_x, rd_len_x;
    logic [EW-1:0] prev_off_x, prev_len_x, prev_end_x, nxt_off_x, nxt_len_x;

    assign idx_m1   = idx_reg - CW'(1);
    assign rd_addr  = cmd.rd_m1 ? idx_m1[IW-1:0] : idx_reg[IW-1:0];

    assign start_x    = EW'(req_start_reg);
    assign amt_x      = EW'(req_amount_reg);
    assign end_x      = start_x + amt_x;
    assign total_x    = EW'(total_size_reg);
    assign rd_off_x   = EW'(rd_data_reg[2*AW-1:AW]);
    assign rd_len_x   = EW'(rd_data_reg[AW-1:0]);
    assign prev_off_x = EW'(prev_off_reg);
    assign prev_len_x = EW'(prev_len_reg);
    assign prev_end_x = prev_off_x + prev_len_x;
    assign nxt_off_x  = EW'(nxt_off_reg);
    assign nxt_len_x  = EW'(nxt_len_reg);

    always_comb
    begin
        st.req_free     = (req_mode_reg == ffa_pkg::MODE_FREE);
        st.amt_zero     = (req_amount_reg == 32'd0);
        st.range_bad    = (start_x > ADDR_MASK) || (end_x > ADDR_MASK);
        st.idx_lt_cnt   = (idx_reg < count_reg);
        st.fit          = (rd_len_x >= amt_x);
        st.exact        = (rd_len_x == amt_x);
        st.off_le_start = (rd_off_x <= start_x);
        st.ovl          = (prev_v_reg && (prev_end_x > start_x))
                       || (nxt_v_reg && (nxt_off_x < end_x));
        st.prev_adj     = prev_v_reg && (prev_end_x == start_x);
        st.nxt_adj      = nxt_v_reg && (nxt_off_x == end_x);
        st.full         = (count_reg >= CW'(MAX_CHUNKS));
        st.rm_more      = (({1'b0, idx_reg} + (CW + 1)'(1)) < {1'b0, count_reg});
        st.ins_more     = (idx_reg > pos_reg);
    end

    always_comb
    begin
        unique case (cmd.wr_addr)
            ffa_pkg::WA_IDX:  wr_addr = idx_reg[IW-1:0];
            ffa_pkg::WA_M1:   wr_addr = idx_m1[IW-1:0];
            default:          wr_addr = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_src)
            ffa_pkg::WS_TRIM:
            begin
                wr_off = AW'(rd_off_x + amt_x);
                wr_len = AW'(rd_len_x - amt_x);
            end
            ffa_pkg::WS_MRG_BOTH:
            begin
                wr_off = prev_off_reg;
                wr_len = AW'(prev_len_x + amt_x + nxt_len_x);
            end
            ffa_pkg::WS_MRG_PREV:
            begin
                wr_off = prev_off_reg;
                wr_len = AW'(prev_len_x + amt_x);
            end
            ffa_pkg::WS_MRG_NXT:
            begin
                wr_off = AW'(start_x);
                wr_len = AW'(nxt_len_x + amt_x);
            end
            ffa_pkg::WS_NEW:
            begin
                wr_off = AW'(start_x);
                wr_len = AW'(amt_x);
            end
            ffa_pkg::WS_INIT:
            begin
                wr_off = '0;
                wr_len = AW'(total_x);
            end
            default:
            begin
                wr_off = rd_data_reg[2*AW-1:AW];
                wr_len = rd_data_reg[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            chunk_mem[wr_addr] <= {wr_off, wr_len};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= chunk_mem[rd_addr];
        end
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            ffa_pkg::IDX_CLR: idx_next = '0;
            ffa_pkg::IDX_INC: idx_next = idx_reg + CW'(1);
            ffa_pkg::IDX_DEC: idx_next = idx_m1;
            ffa_pkg::IDX_CNT: idx_next = count_reg;
            default:          idx_next = idx_reg;
        endcase

        priority if (cmd.init)
        begin
            count_next = (total_size_reg != 32'd0) ? CW'(1) : '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        prev_v_next = cmd.nb_clr ? 1'b0 : (cmd.prev_ld ? 1'b1 : prev_v_reg);
        nxt_v_next  = cmd.nb_clr ? 1'b0 : (cmd.nxt_ld ? 1'b1 : nxt_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg <= TOTAL_RESET;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            prev_v_reg     <= 1'b0;
            nxt_v_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (total_size_we)
            begin
                total_size_reg <= total_size_wdata;
            end
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            if (cmd.pos_ld)
            begin
                pos_reg <= idx_reg;
            end
            prev_v_reg <= prev_v_next;
            nxt_v_reg  <= nxt_v_next;
            done_reg   <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_mode_reg   <= mode;
            req_amount_reg <= amount;
            req_start_reg  <= start_req;
        end
        if (cmd.prev_ld)
        begin
            prev_off_reg <= rd_data_reg[2*AW-1:AW];
            prev_len_reg <= rd_data_reg[AW-1:0];
        end
        if (cmd.nxt_ld)
        begin
            nxt_off_reg <= rd_data_reg[2*AW-1:AW];
            nxt_len_reg <= rd_data_reg[AW-1:0];
        end
        if (cmd.res_wr)
        begin
            res_off_reg    <= cmd.res_alloc ? rd_off_x[31:0] : 32'd0;
            res_len_reg    <= cmd.res_alloc ? req_amount_reg : 32'd0;
            res_status_reg <= cmd.res_code;
        end
    end

    assign offset_out = res_off_reg;
    assign length_out = res_len_reg;
    assign status     = res_status_reg;
    assign done       = done_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CHUNKS))
        else $error("chunk count beyond table depth");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CW'(MAX_CHUNKS)))
        else $error("insert into a full table");

    a_remove_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("remove from an empty table");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

endmodule

FILE: sim/ffa_checker.sv
// ffa_checker: scoreboard for first_fit_free_list_allocator_core, keeps its own free-chunk table
// predicts every result from the accepted requests and total_size writes; needs ffa_pkg
module ffa_checker
    import ffa_pkg::*;
#(
    parameter int MAX_CHUNKS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                mode,
    input  logic [31:0]         amount,
    input  logic [31:0]         start_req,
    input  logic                total_size_we,
    input  logic [31:0]         total_size_wdata,
    input  logic                done,
    input  logic [31:0]         offset_out,
    input  logic [31:0]         length_out,
    input  logic [STATUS_W-1:0] status,
    output int                  fail_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] RESET_SIZE  = 32'd65536;

    typedef struct packed {
        logic [31:0]         off;
        logic [31:0]         len;
        logic [STATUS_W-1:0] st;
    } grant_t;

    logic [31:0] size_reg;
    logic [31:0] free_off [MAX_CHUNKS];
    logic [31:0] free_len [MAX_CHUNKS];
    int          free_cnt;
    grant_t      expected_q [$];
    int          errs;

    function automatic void rebuild_table();
        free_cnt = 0;
        if (size_reg != 0)
        begin
            free_off[0] = '0;
            free_len[0] = size_reg;
            free_cnt    = 1;
        end
    endfunction

    function automatic void drop_entry(int p);
        for (int k = p; k + 1 < free_cnt; k++)
        begin
            free_off[k] = free_off[k + 1];
            free_len[k] = free_len[k + 1];
        end
        free_cnt--;
    endfunction

    function automatic void add_entry(int p, logic [31:0] off, logic [31:0] len);
        for (int k = free_cnt; k > p; k--)
        begin
            free_off[k] = free_off[k - 1];
            free_len[k] = free_len[k - 1];
        end
        free_off[p] = off;
        free_len[p] = len;
        free_cnt++;
    endfunction

    // lowest-offset chunk that is big enough gives up space from its front
    function automatic grant_t predict_alloc(logic [31:0] amt);
        grant_t g;
        g    = '0;
        g.st = ST_NOSPACE;
        for (int i = 0; i < free_cnt; i++)
        begin
            if (free_len[i] >= amt)
            begin
                g.off = free_off[i];
                g.len = amt;
                g.st  = ST_OK;
                if (free_len[i] == amt)
                    drop_entry(i);
                else
                begin
                    free_off[i] += amt;
                    free_len[i] -= amt;
                end
                return g;
            end
        end
        return g;
    endfunction

    function automatic logic [STATUS_W-1:0] predict_release(logic [31:0] base,
                                                            logic [31:0] amt);
        logic [32:0] stop;
        logic [32:0] prev_stop;
        int          p;
        logic        prev_adj;
        logic        next_adj;
        if (amt == 0)
            return ST_OK;
        stop = {1'b0, base} + {1'b0, amt};
        if (stop > 33'h0_FFFF_FFFF)
            return ST_BADFREE;
        p = 0;
        while (p < free_cnt && free_off[p] <= base)
            p++;
        prev_adj = 1'b0;
        next_adj = 1'b0;
        if (p > 0)
        begin
            prev_stop = {1'b0, free_off[p - 1]} + {1'b0, free_len[p - 1]};
            if (prev_stop > {1'b0, base})
                return ST_BADFREE;
            prev_adj = (prev_stop == {1'b0, base});
        end
        if (p < free_cnt)
        begin
            if ({1'b0, free_off[p]} < stop)
                return ST_BADFREE;
            next_adj = ({1'b0, free_off[p]} == stop);
        end
        if (prev_adj && next_adj)
        begin
            free_len[p - 1] += amt + free_len[p];
            drop_entry(p);
        end
        else if (prev_adj)
            free_len[p - 1] += amt;
        else if (next_adj)
        begin
            free_off[p] = base;
            free_len[p] += amt;
        end
        else if (free_cnt >= MAX_CHUNKS)
            return ST_FULL;
        else
            add_entry(p, base, amt);
        return ST_OK;
    endfunction

    function automatic grant_t predict_grant(logic m, logic [31:0] amt, logic [31:0] base);
        grant_t g;
        if (m == MODE_ALLOC)
            return predict_alloc(amt);
        g    = '0;
        g.st = predict_release(base, amt);
        return g;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errs++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            size_reg = RESET_SIZE;
            rebuild_table();
            expected_q.delete();
            errs = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: expected no result got offset %h length %h status %0d",
                             $time, offset_out, length_out, status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("offset_out", want.off, offset_out);
                    check_field("length_out", want.len, length_out);
                    check_field("status", 32'(want.st), 32'(status));
                end
            end
            if (total_size_we)
            begin
                size_reg = total_size_wdata;
                rebuild_table();
            end
            if (start && !busy)
                expected_q.push_back(predict_grant(mode, amount, start_req));
            fail_count  <= errs;
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: sim/tb_first_fit_free_list_allocator_core.sv
// tb_first_fit_free_list_allocator_core: stimulus and verdict for the free-list allocator
// drives directed then random allocate/free traffic over several buffer sizes;
// depends on ffa_pkg, ffa_checker and first_fit_free_list_allocator_core
module tb_first_fit_free_list_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 28;
    localparam int NUM_DIRECTED = 23;

    typedef struct packed {
        logic [31:0] off;
        logic [31:0] len;
    } span_t;

    typedef struct packed {
        logic        m;
        logic [31:0] amt;
        logic [31:0] base;
        span_t       back;
    } req_t;

    typedef struct packed {
        logic        m;
        logic [31:0] amt;
        logic [31:0] base;
    } op_t;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                start            = 1'b0;
    logic                mode             = 1'b0;
    logic [31:0]         amount           = '0;
    logic [31:0]         start_req        = '0;
    logic                total_size_we    = 1'b0;
    logic [31:0]         total_size_wdata = '0;
    logic                busy;
    logic                done;
    logic [31:0]         offset_out;
    logic [31:0]         length_out;
    logic [STATUS_W-1:0] status;
    int                  fail_count;
    int                  outstanding;
    int                  cycle_count;
    bit                  idle_on;
    span_t               held_q [$];
    span_t               restore_q [$];

    logic [31:0] phase_size [NUM_PHASES] = '{
        32'd1, 32'hFFFF_FFFF, 32'd4096, 32'd300, 32'd0, 32'd65536, 32'd2048, 32'd977
    };

    op_t plan [NUM_DIRECTED] = '{
        '{MODE_ALLOC, 32'd0,          32'hFFFF_FFFF},
        '{MODE_ALLOC, 32'd65537,      32'd0},
        '{MODE_ALLOC, 32'hFFFF_FFFF,  32'd0},
        '{MODE_ALLOC, 32'd100,        32'd0},
        '{MODE_ALLOC, 32'd200,        32'd0},
        '{MODE_ALLOC, 32'd300,        32'd0},
        '{MODE_FREE,  32'd0,          32'd1234},
        '{MODE_FREE,  32'd200,        32'd100},
        '{MODE_FREE,  32'd60,         32'd50},
        '{MODE_FREE,  32'd10,         32'd250},
        '{MODE_FREE,  32'd100,        32'd0},
        '{MODE_FREE,  32'd300,        32'd300},
        '{MODE_ALLOC, 32'd65536,      32'd0},
        '{MODE_ALLOC, 32'd1,          32'd0},
        '{MODE_ALLOC, 32'd0,          32'd0},
        '{MODE_FREE,  32'd100,        32'd65536},
        '{MODE_FREE,  32'd10,         32'd65636},
        '{MODE_FREE,  32'd1,          32'hFFFF_FFFF},
        '{MODE_FREE,  32'd1,          32'hFFFF_FFFE},
        '{MODE_FREE,  32'hFFFF_FFFF,  32'd1},
        '{MODE_FREE,  32'hFFFF_FFFF,  32'd0},
        '{MODE_ALLOC, 32'd40,         32'h5A5A_A5A5},
        '{MODE_FREE,  32'd40,         32'd65536}
    };

    first_fit_free_list_allocator_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .amount           (amount),
        .start_req        (start_req),
        .total_size_we    (total_size_we),
        .total_size_wdata (total_size_wdata),
        .done             (done),
        .offset_out       (offset_out),
        .length_out       (length_out),
        .status           (status)
    );

    ffa_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .amount           (amount),
        .start_req        (start_req),
        .total_size_we    (total_size_we),
        .total_size_wdata (total_size_wdata),
        .done             (done),
        .offset_out       (offset_out),
        .length_out       (length_out),
        .status           (status),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[first_fit_free_list_allocator_core] ERROR");
        $finish;
    end

    // track granted ranges so that later frees hit real allocations
    always @(posedge clk)
    begin
        span_t back;
        if (rst_n && done && restore_q.size() != 0)
        begin
            back = restore_q.pop_front();
            if (status == ST_OK && length_out != 0)
                held_q.push_back(span_t'{offset_out, length_out});
            else if (status == ST_FULL && back.len != 0)
                held_q.push_back(back);
        end
    end

    task automatic send_request(input logic m, input logic [31:0] amt,
                                input logic [31:0] base, input span_t back);
        mode      <= m;
        amount    <= amt;
        start_req <= base;
        // hold the request until the transfer is taken
        forever
        begin
            start <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
            if (start && !busy)
                break;
        end
        restore_q.push_back(back);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
    endtask

    task automatic program_size(input logic [31:0] sz);
        drain();
        total_size_we    <= 1'b1;
        total_size_wdata <= sz;
        @(posedge clk);
        total_size_we <= 1'b0;
        held_q.delete();
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic req_t pick_request(logic [31:0] sz);
        req_t        r;
        span_t       s;
        int          roll;
        int          idx;
        logic [31:0] cut;
        logic [31:0] gap;
        logic [31:0] cap;
        r      = '0;
        r.base = $urandom;
        cap    = (sz / 20 == 0) ? 32'd1 : sz / 20;
        roll   = $urandom_range(0, 99);
        if (roll < 45 || (roll < 85 && held_q.size() == 0))
        begin
            r.m  = MODE_ALLOC;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                r.amt = '0;
            else if (roll < 7)
                r.amt = $urandom;
            else if (roll < 9)
                r.amt = sz;
            else
                r.amt = $urandom_range(1, cap);
        end
        else if (roll < 85)
        begin
            // give back a held range, whole or a piece of it
            r.m  = MODE_FREE;
            idx  = $urandom_range(0, held_q.size() - 1);
            s    = held_q[idx];
            held_q.delete(idx);
            r.base = s.off;
            r.amt  = s.len;
            roll   = $urandom_range(0, 3);
            if (s.len > 2 && roll != 0)
            begin
                cut = $urandom_range(1, s.len - 2);
                if (roll == 1)
                begin
                    r.amt = cut;
                    held_q.push_back(span_t'{s.off + cut, s.len - cut});
                end
                else if (roll == 2)
                begin
                    r.base = s.off + cut;
                    r.amt  = s.len - cut;
                    held_q.push_back(span_t'{s.off, cut});
                end
                else
                begin
                    gap    = $urandom_range(1, s.len - 1 - cut);
                    r.base = s.off + cut;
                    r.amt  = gap;
                    held_q.push_back(span_t'{s.off, cut});
                    held_q.push_back(span_t'{s.off + cut + gap, s.len - cut - gap});
                end
            end
            r.back = span_t'{r.base, r.amt};
        end
        else
        begin
            // stray frees: overlaps, past the buffer, past the address space, zero length
            r.m  = MODE_FREE;
            roll = $urandom_range(0, 4);
            case (roll)
                0:
                begin
                    r.base = $urandom_range(0, sz);
                    r.amt  = $urandom_range(1, cap);
                end
                1:
                    r.amt = $urandom;
                2:
                begin
                    r.base = sz + $urandom_range(0, 64);
                    r.amt  = $urandom_range(1, 64);
                end
                3:
                begin
                    r.base = 32'hFFFF_FFFF - $urandom_range(0, 64);
                    r.amt  = $urandom_range(0, 128);
                end
                default:
                    r.amt = '0;
            endcase
        end
        return r;
    endfunction

    initial
    begin
        req_t        r;
        logic [31:0] sz;
        idle_on = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(plan[i].m, plan[i].amt, plan[i].base, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            sz = (ph == 4) ? 32'($urandom_range(1000, 2000000)) : phase_size[ph];
            program_size(sz);
            idle_on = (ph != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                r = pick_request(sz);
                send_request(r.m, r.amt, r.base, r.back);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[first_fit_free_list_allocator_core] OK");
        else
            $display("[first_fit_free_list_allocator_core] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ffa_pkg.sv
hdl/ffa_ctrl.sv
hdl/ffa_dp.sv
hdl/first_fit_free_list_allocator_core.sv
sim/ffa_checker.sv
sim/tb_first_fit_free_list_allocator_core.sv
